[src/rdc_pkg.sv]
// Shared types, constants and helpers for the radix digit converter.
`timescale 1ns / 1ps

package rdc_pkg;

   // Fixed field widths of the request and response payloads
   localparam int VALUE_WIDTH   = 32;
   localparam int BASE_WIDTH    = 8;
   localparam int CHAR_WIDTH    = 8;
   localparam int DIGIT_WIDTH   = 4;
   localparam int REM_WIDTH     = DIGIT_WIDTH + 1;

   // Divider: quotient bits retired per cycle and divider steps per digit
   localparam int BITS_PER_STEP = 8;
   localparam int DIV_STEPS     = VALUE_WIDTH / BITS_PER_STEP;
   localparam int STEP_CNT_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   // Legal radix range
   localparam logic [BASE_WIDTH-1:0] BASE_MIN = BASE_WIDTH'(2);
   localparam logic [BASE_WIDTH-1:0] BASE_MAX = BASE_WIDTH'(16);

   // ASCII anchors for digit glyphs
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ALPHA  = 8'h37;  // 'A' - 10
   localparam logic [DIGIT_WIDTH-1:0] DEC_LIMIT  = 4'd10;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic [BASE_WIDTH-1:0]  base;
   } req_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] digit_char;
      logic                  last_digit;
      logic                  base_error;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load_req;
      logic div_step;
      logic store_digit;
      logic read_digit;
      logic emit_digit;
      logic emit_error;
      logic dec_index;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic base_bad;
      logic step_last;
      logic more_digits;
      logic index_zero;
      logic out_free;
   } status_type;

   // Digit value to ASCII character
   function automatic logic [CHAR_WIDTH-1:0] glyph(input logic [DIGIT_WIDTH-1:0] d);
      logic [CHAR_WIDTH-1:0] ext;
      ext = {{(CHAR_WIDTH-DIGIT_WIDTH){1'b0}}, d};
      if (d < DEC_LIMIT) begin
         return CHAR_ZERO + ext;
      end else begin
         return CHAR_ALPHA + ext;
      end
   endfunction

endpackage

[src/rdc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rdc_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/rdc_ctrl.sv]
// Sequencing state machine for the radix digit converter.
`timescale 1ns / 1ps

module rdc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rdc_pkg::status_type status,
   output rdc_pkg::cmd_type    cmd
);

   import rdc_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_ERR   = 6'b000010,
      S_DIV   = 6'b000100,
      S_STORE = 6'b001000,
      S_READ  = 6'b010000,
      S_LOAD  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Next state and command decode
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = status.base_bad ? S_ERR : S_DIV;
            end
         end
         S_ERR: begin
            if (status.out_free) begin
               cmd.emit_error = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.step_last) begin
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            cmd.store_digit = 1'b1;
            state_in        = status.more_digits ? S_DIV : S_READ;
         end
         S_READ: begin
            cmd.read_digit = 1'b1;
            state_in       = S_LOAD;
         end
         S_LOAD: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.index_zero) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.dec_index = 1'b1;
                  state_in      = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/rdc_datapath.sv]
// Divider, digit store and response register for the radix digit converter.
`timescale 1ns / 1ps

module rdc_datapath #(
   parameter int MAX_DIGITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  rdc_pkg::req_type    req_data,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output rdc_pkg::rsp_type    rsp_data,
   input  rdc_pkg::cmd_type    cmd,
   output rdc_pkg::status_type status
);

   import rdc_pkg::*;

   localparam int AW = $clog2(MAX_DIGITS);
   localparam int CW = $clog2(MAX_DIGITS + 1);

   logic [VALUE_WIDTH-1:0] quot_ff, quot_in;
   logic [REM_WIDTH-1:0]   base_ff, base_in;
   logic [DIGIT_WIDTH-1:0] rem_ff, rem_in;
   logic [STEP_CNT_W-1:0]  step_ff, step_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          index_ff, index_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [REM_WIDTH-1:0]     rem_v;
   logic [BITS_PER_STEP-1:0] top_bits;
   logic [BITS_PER_STEP-1:0] q_bits;
   logic [DIGIT_WIDTH-1:0]   rd_digit;
   logic [CW-1:0]            count_next;

   // Restoring division of the top byte of the quotient by the base
   always_comb begin
      top_bits = quot_ff[VALUE_WIDTH-1 -: BITS_PER_STEP];
      rem_v    = {1'b0, rem_ff};
      q_bits   = '0;
      for (int j = BITS_PER_STEP - 1; j >= 0; j--) begin
         rem_v = {rem_v[DIGIT_WIDTH-1:0], top_bits[j]};
         if (rem_v >= base_ff) begin
            q_bits[j] = 1'b1;
            rem_v     = rem_v - base_ff;
         end
      end
   end

   assign count_next = count_ff + CW'(1);

   // Status back to the controller
   always_comb begin
      status.base_bad    = (req_data.base < BASE_MIN) || (req_data.base > BASE_MAX);
      status.step_last   = (step_ff == STEP_CNT_W'(DIV_STEPS - 1));
      status.more_digits = (quot_ff != '0) && (count_next < CW'(MAX_DIGITS));
      status.index_zero  = (index_ff == '0);
      status.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // Working registers
   always_comb begin
      quot_in  = quot_ff;
      base_in  = base_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      count_in = count_ff;
      index_in = index_ff;
      if (cmd.load_req) begin
         quot_in  = req_data.value;
         base_in  = req_data.base[REM_WIDTH-1:0];
         rem_in   = '0;
         step_in  = '0;
         count_in = '0;
      end
      if (cmd.div_step) begin
         quot_in = {quot_ff[VALUE_WIDTH-BITS_PER_STEP-1:0], q_bits};
         rem_in  = rem_v[DIGIT_WIDTH-1:0];
         step_in = step_ff + STEP_CNT_W'(1);
      end
      if (cmd.store_digit) begin
         rem_in   = '0;
         step_in  = '0;
         count_in = count_next;
         index_in = count_ff[AW-1:0];
      end
      if (cmd.dec_index) begin
         index_in = index_ff - AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quot_ff  <= '0;
         step_ff  <= '0;
         count_ff <= '0;
         index_ff <= '0;
      end else begin
         quot_ff  <= quot_in;
         step_ff  <= step_in;
         count_ff <= count_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      rem_ff  <= rem_in;
   end

   // Digit store, written least significant digit first, read back in reverse
   rdc_ram #(
      .WIDTH (DIGIT_WIDTH),
      .DEPTH (MAX_DIGITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.store_digit),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (rem_ff),
      .rd_en   (cmd.read_digit),
      .rd_addr (index_ff),
      .rd_data (rd_digit)
   );

   // Response register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_digit) begin
         rsp_in.digit_char = glyph(rd_digit);
         rsp_in.last_digit = (index_ff == '0);
         rsp_in.base_error = 1'b0;
         rsp_valid_in      = 1'b1;
      end else if (cmd.emit_error) begin
         rsp_in.digit_char = '0;
         rsp_in.last_digit = 1'b1;
         rsp_in.base_error = 1'b1;
         rsp_valid_in      = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[src/radix_digit_converter_unit.sv]
// Top level: binary to radix-k ASCII digit converter.
// Operation: a valid base with D digits is divided digit by digit (four 8-bit
//   divider steps plus one store per digit), then each digit is read and emitted.
// Flow: one request at a time, with one divider and a single read port on the
//   digit store; a new request is taken only after the last response is emitted.
// Reset: synchronous, clears the state machine, counters and response valid.
`timescale 1ns / 1ps

module radix_digit_converter_unit #(
   parameter int MAX_DIGITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rdc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rdc_pkg::rsp_type rsp_data
);

   import rdc_pkg::*;

   cmd_type    cmd;
   status_type status;

   rdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rdc_datapath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

[src/rdc_checker.sv]
// Port-level checks for the radix digit converter, bound to the top level.
`timescale 1ns / 1ps

module rdc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input rdc_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rdc_pkg::rsp_type rsp_data
);

   import rdc_pkg::*;

   // A waiting request holds its payload
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request changed while waiting");

   // A stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // An error response is a lone, blank, final character
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.base_error |->
         rsp_data.last_digit && (rsp_data.digit_char == '0))
      else $error("malformed error response");

   // A normal response carries a digit glyph
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.base_error |->
         (rsp_data.digit_char >= 8'h30 && rsp_data.digit_char <= 8'h39) ||
         (rsp_data.digit_char >= 8'h41 && rsp_data.digit_char <= 8'h46))
      else $error("response is not a digit character");

   // One request at a time: the block is busy right after taking a request
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

endmodule

bind radix_digit_converter_unit rdc_checker u_rdc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[verif/radix_digit_converter_checker.sv]
// Checker for the radix digit converter: predicts digit responses and compares them.
`timescale 1ns / 1ps

module radix_digit_converter_checker #(
   parameter int MAX_DIGITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  rdc_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rdc_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               pending_count
);

   import rdc_pkg::*;

   // Digit glyphs, leftmost character in the top byte
   localparam logic [16*CHAR_WIDTH-1:0] GLYPHS = "0123456789ABCDEF";

   rsp_type                expected_chars[$];
   logic [DIGIT_WIDTH-1:0] digit_store [MAX_DIGITS];
   int                     digit_count = 0;
   logic [VALUE_WIDTH-1:0] running_quotient = '0;
   int                     errors = 0;

   // Convert one request and queue its characters, most significant first
   function automatic void predict_conversion(input req_type r);
      rsp_type ch;
      int      i;
      if (r.base < BASE_MIN || r.base > BASE_MAX) begin
         // bad radix: one flagged response, state untouched
         ch.digit_char = '0;
         ch.last_digit = 1'b1;
         ch.base_error = 1'b1;
         expected_chars.push_back(ch);
         return;
      end
      running_quotient = r.value;
      digit_count      = 0;
      do begin
         digit_store[digit_count] =
            DIGIT_WIDTH'(running_quotient % VALUE_WIDTH'(r.base));
         running_quotient = running_quotient / VALUE_WIDTH'(r.base);
         digit_count++;
      end while (running_quotient != '0 && digit_count < MAX_DIGITS);
      for (i = digit_count - 1; i >= 0; i--) begin
         ch.digit_char = GLYPHS[CHAR_WIDTH*(15 - int'(digit_store[i])) +: CHAR_WIDTH];
         ch.last_digit = (i == 0);
         ch.base_error = 1'b0;
         expected_chars.push_back(ch);
      end
   endfunction

   // Responses are checked before the same edge's request is predicted
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         digit_count      = 0;
         running_quotient = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected response: digit_char %h last_digit %b base_error %b",
                      rsp_data.digit_char, rsp_data.last_digit, rsp_data.base_error);
               errors++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_data.digit_char !== want.digit_char) begin
                  $error("digit_char: expected %h, actual %h",
                         want.digit_char, rsp_data.digit_char);
                  errors++;
               end
               if (rsp_data.last_digit !== want.last_digit) begin
                  $error("last_digit: expected %b, actual %b",
                         want.last_digit, rsp_data.last_digit);
                  errors++;
               end
               if (rsp_data.base_error !== want.base_error) begin
                  $error("base_error: expected %b, actual %b",
                         want.base_error, rsp_data.base_error);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_conversion(req_data);
         end
      end
      mismatch_count <= errors;
      pending_count  <= expected_chars.size();
   end

endmodule

[verif/radix_digit_converter_unit_test.sv]
// Testbench top for the radix digit converter: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module radix_digit_converter_unit_test;

   import rdc_pkg::*;

   localparam int RESET_CYCLES     = 6;
   localparam int RX_HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES     = 250;  // longest conversion plus emit
   localparam int QUIET_LIMIT      = 4000;
   localparam int RANDOM_PER_PHASE = 70;
   localparam int HOLD_REQUESTS    = 30;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int mismatch_count;
   int pending_count;
   int tx_idle_pct      = 0;
   int rx_idle_pct      = 0;
   int rx_hold_requests = 0;
   int rx_hold_seen     = 0;
   int rx_hold_left     = 0;
   int quiet_cycles     = 0;

   radix_digit_converter_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   radix_digit_converter_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic req_type conversion_request(input logic [VALUE_WIDTH-1:0] v,
                                                  input logic [BASE_WIDTH-1:0] b);
      req_type r;
      r.value = v;
      r.base  = b;
      return r;
   endfunction

   // Mostly legal radixes; values biased toward edges and short numbers
   function automatic req_type random_request();
      logic [VALUE_WIDTH-1:0] v;
      logic [BASE_WIDTH-1:0]  b;
      int                     roll;
      roll = $urandom_range(99);
      if (roll < 15) begin
         b = ($urandom_range(3) == 0) ? BASE_WIDTH'($urandom_range(1))
                                      : BASE_WIDTH'($urandom_range(255, 17));
      end else begin
         b = BASE_WIDTH'($urandom_range(16, 2));
      end
      roll = $urandom_range(99);
      if (roll < 55) begin
         v = $urandom;
      end else if (roll < 75) begin
         v = $urandom_range(255);
      end else if (roll < 85) begin
         v = ($urandom_range(1) == 0) ? '0 : '1;
      end else begin
         v = $urandom >> $urandom_range(31);
      end
      return conversion_request(v, b);
   endfunction

   // Offer one request, with random idle cycles ahead of it
   task automatic send_request(input req_type r);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Stop offering until every predicted character has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      for (int n = 0; n < count; n++) begin
         send_request(random_request());
      end
   endtask

   // Receiver: random stalls, plus a long hold-off on demand
   always @(posedge clock) begin
      if (rx_hold_seen != rx_hold_requests) begin
         rx_hold_seen <= rx_hold_requests;
         rx_hold_left <= RX_HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else if (rx_hold_left != 0) begin
         rx_hold_left <= rx_hold_left - 1;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Watchdog on cycles with no request or response accepted
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every legal radix, then zero, extremes and bad radixes
      for (int b = 2; b <= 16; b++) begin
         if (b == 2 || b == 16) begin
            send_request(conversion_request('1, BASE_WIDTH'(b)));
         end else if (b == 10) begin
            send_request(conversion_request('0, BASE_WIDTH'(b)));
         end else begin
            send_request(conversion_request($urandom, BASE_WIDTH'(b)));
         end
      end
      send_request(conversion_request(32'h8000_0000, 8'd2));
      send_request(conversion_request(32'd16, 8'd16));
      send_request(conversion_request(32'd1, 8'd3));
      send_request(conversion_request('0, 8'd7));
      send_request(conversion_request('1, 8'd0));
      send_request(conversion_request('0, 8'd1));
      send_request(conversion_request(32'd12345, 8'd17));
      send_request(conversion_request('1, 8'd255));
      wait_for_drain();

      // Sender idles lightly, receiver heavily; long receiver hold-off inside
      tx_idle_pct = 38;
      rx_idle_pct <= 68;
      send_random(RANDOM_PER_PHASE - HOLD_REQUESTS);
      rx_hold_requests <= rx_hold_requests + 1;
      send_random(HOLD_REQUESTS);
      wait_for_drain();

      // Roles swapped
      tx_idle_pct = 68;
      rx_idle_pct <= 38;
      send_random(RANDOM_PER_PHASE);
      wait_for_drain();

      // Back to back with no idling
      tx_idle_pct = 0;
      rx_idle_pct <= 0;
      send_random(RANDOM_PER_PHASE);
      wait_for_drain();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
